// ===== rtl/gtg_pkg.sv =====
// Shared types, constants and the arctangent table of the go-to-goal controller.
`default_nettype none
package gtg_pkg;

    // default number of CORDIC iterations, table holds 24
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_DEPTH       = 24;

    // datapath widths
    localparam int DW  = 18;   // goal offset, Q8.8
    localparam int XW  = 34;   // CORDIC x and y, Q8.20
    localparam int ZW  = 34;   // CORDIC angle, Q2.30 plus headroom
    localparam int RW  = 19;   // distance, Q8.8 unsigned
    localparam int MAW = 30;   // serial multiplier multiplicand
    localparam int MBW = 34;   // serial multiplier multiplier
    localparam int MPW = 64;   // serial multiplier product
    localparam int MLW = 6;    // multiplier length field

    // fixed point constants
    localparam logic [MAW-1:0]       CORDIC_K_Q30 = 30'd652032874;
    localparam logic signed [ZW-1:0] HALF_PI_Q30  = 34'sd1686629713;
    localparam logic signed [16:0]   PI_Q12       = 17'sd12868;
    localparam logic signed [16:0]   TWO_PI_Q12   = 17'sd25736;
    localparam logic signed [15:0]   PI_9_Q12     = 16'sd1430;

    // input modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_STEP  = 2'd1;

    // status codes
    localparam logic [1:0] STAT_INIT = 2'd0;
    localparam logic [1:0] STAT_RUN  = 2'd1;
    localparam logic [1:0] STAT_DONE = 2'd2;
    localparam logic [1:0] STAT_TERM = 2'd3;

    // configuration register indexes
    localparam int CFG_IW = 4;
    localparam logic [CFG_IW-1:0] CFG_GOAL_X      = 4'd0;
    localparam logic [CFG_IW-1:0] CFG_GOAL_Y      = 4'd1;
    localparam logic [CFG_IW-1:0] CFG_RELATIVE    = 4'd2;
    localparam logic [CFG_IW-1:0] CFG_ARRIVE      = 4'd3;
    localparam logic [CFG_IW-1:0] CFG_GAIN_LIN    = 4'd4;
    localparam logic [CFG_IW-1:0] CFG_GAIN_ANG    = 4'd5;
    localparam logic [CFG_IW-1:0] CFG_MAX_LIN     = 4'd6;
    localparam logic [CFG_IW-1:0] CFG_MAX_ANG     = 4'd7;

    // request to the serial multiplier
    typedef struct packed {
        logic           start;
        logic [MLW-1:0] len;
    } t_mul_req;

    // arctangent of 2^-i in Q2.30
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/gtg_sermul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle, MSB first.
`default_nettype none
module gtg_sermul
    import gtg_pkg::*;
#(
    parameter int A_W = MAW,
    parameter int B_W = MBW,
    parameter int P_W = MPW
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire t_mul_req       i_req,
    input  wire logic [A_W-1:0] i_a,
    input  wire logic [B_W-1:0] i_b,
    output logic [P_W-1:0]      o_prod,
    output logic                o_done
);

    logic [A_W-1:0] r_a;
    logic [B_W-1:0] r_b;
    logic [P_W-1:0] r_acc;
    logic [MLW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;

    // control: load on start, count bits down, flag the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_req.len;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != MLW'(1));
            r_done <= (r_cnt == MLW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    // datapath: align multiplier to the top, shift and accumulate
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_a;
            r_b   <= i_b << (MLW'(B_W) - i_req.len);
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= (r_acc << 1) + (r_b[B_W-1] ? P_W'(r_a) : P_W'(0));
            r_b   <= r_b << 1;
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;

endmodule
`default_nettype wire

// ===== rtl/go_to_goal_velocity_controller.sv =====
// Go-to-goal proportional velocity controller, top level.
// Input channel: i_valid / o_stall carry a mode (start, step, stop) and the
// pose; a transfer happens when i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall carry status, command_valid and the
// linear and angular velocity; one result per input item, in order.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx; write
// only while no item is in flight. Unknown indexes are ignored.
// Sequence: start and stop skip the computation and go to the done state. A
// step runs the pre-rotation, min(CORDIC_STEPS, 24) iterations of one shared
// CORDIC stage, the bit-serial gain correction and an evaluation step; that
// is all when the goal is reached or the robot turns in place, and the two
// serial multiplies of a proportional command follow otherwise. The
// bit-serial multiplier sets the pace.
// One item is worked on at a time; the next is taken once the result is
// parked in the output register, so a stalled receiver holds the result
// there and blocks the next item only after its computation finishes.
// Reset: synchronous, active low; registers return to their documented
// values and the latched origin to zero.
`default_nettype none
module go_to_goal_velocity_controller
    import gtg_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_mode,
    input  wire logic [15:0]       i_pose_x,
    input  wire logic [15:0]       i_pose_y,
    input  wire logic [14:0]       i_pose_heading,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [1:0]             o_status,
    output logic                   o_command_valid,
    output logic [15:0]            o_linear_velocity,
    output logic [15:0]            o_angular_velocity,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_IW-1:0] i_cfg_idx,
    input  wire logic [15:0]       i_cfg_data
);

    localparam int NIT = (CORDIC_STEPS < ATAN_DEPTH) ? CORDIC_STEPS : ATAN_DEPTH;
    localparam logic [4:0] LAST_IT = 5'(NIT - 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PRE  = 8'b0000_0010,
        S_CORD = 8'b0000_0100,
        S_MAG  = 8'b0000_1000,
        S_EVAL = 8'b0001_0000,
        S_LIN  = 8'b0010_0000,
        S_ANG  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    // configuration and origin
    logic signed [15:0] r_goal_x, r_goal_y, r_org_x, r_org_y;
    logic               r_relative;
    logic [14:0]        r_arrive, r_max_lin, r_max_ang;
    logic [15:0]        r_gain_lin, r_gain_ang;

    // item state
    t_state                r_state, n_state;
    logic signed [14:0]    r_th;
    logic signed [DW-1:0]  r_dx, r_dy;
    logic signed [XW-1:0]  r_x, r_y;
    logic signed [ZW-1:0]  r_z;
    logic [4:0]            r_i;
    logic [RW-1:0]         r_r;
    logic signed [15:0]    r_alpha;
    logic [1:0]            r_stat;
    logic                  r_cv;
    logic [15:0]           r_lin, r_ang;

    // output register
    logic        r_ovalid, r_ocv;
    logic [1:0]  r_ostat;
    logic [15:0] r_olin, r_oang;

    logic        in_xfer, out_free;
    t_mul_req    mul_req;
    logic [MAW-1:0] mul_a;
    logic [MBW-1:0] mul_b;
    logic [MPW-1:0] mul_p;
    logic        mul_done;

    assign in_xfer  = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x   <= '0;
            r_goal_y   <= '0;
            r_relative <= 1'b0;
            r_arrive   <= 15'd26;
            r_gain_lin <= 16'd4096;
            r_gain_ang <= 16'd4096;
            r_max_lin  <= 15'd4096;
            r_max_ang  <= 15'd4096;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GOAL_X:   r_goal_x   <= i_cfg_data;
                CFG_GOAL_Y:   r_goal_y   <= i_cfg_data;
                CFG_RELATIVE: r_relative <= i_cfg_data[0];
                CFG_ARRIVE:   r_arrive   <= i_cfg_data[14:0];
                CFG_GAIN_LIN: r_gain_lin <= i_cfg_data;
                CFG_GAIN_ANG: r_gain_ang <= i_cfg_data;
                CFG_MAX_LIN:  r_max_lin  <= i_cfg_data[14:0];
                CFG_MAX_ANG:  r_max_ang  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // latch the origin on a start transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
        end else if (in_xfer && i_mode == MODE_START) begin
            r_org_x <= r_relative ? i_pose_x : 16'sd0;
            r_org_y <= r_relative ? i_pose_y : 16'sd0;
        end
    end

    // CORDIC stage operands
    logic signed [XW-1:0] x0, y0, xs, ys, x_nx;
    logic signed [ZW-1:0] atan_z;
    assign x0     = {{(XW-DW-12){r_dx[DW-1]}}, r_dx, 12'b0};
    assign y0     = {{(XW-DW-12){r_dy[DW-1]}}, r_dy, 12'b0};
    assign xs     = r_x >>> r_i;
    assign ys     = r_y >>> r_i;
    assign x_nx   = r_y[XW-1] ? r_x - ys : r_x + ys;
    assign atan_z = signed'({{(ZW-30){1'b0}}, atan_q30(r_i)});

    // magnitude and bearing from the finished CORDIC
    logic [MPW-1:0]       mag_sum;
    logic signed [ZW-1:0] z_rnd;
    logic signed [16:0]   bearing, alpha_raw, alpha_w;
    assign mag_sum  = mul_p + (MPW'(1) << 41);
    assign z_rnd    = r_z + ZW'(131072);
    assign bearing  = (r_dx == '0 && r_dy == '0) ? 17'sd0 :
                      17'(signed'(z_rnd[ZW-1:18]));
    assign alpha_raw = bearing - 17'(r_th);
    always_comb begin
        if (alpha_raw > PI_Q12)
            alpha_w = alpha_raw - TWO_PI_Q12;
        else if (alpha_raw < -PI_Q12)
            alpha_w = alpha_raw + TWO_PI_Q12;
        else
            alpha_w = alpha_raw;
    end

    // turn decision and scaled velocities
    logic               turn;
    logic [15:0]        max_ang16;
    logic [35:0]        lin_sum;
    logic [27:0]        lin_q;
    logic [26:0]        ang_mag;
    logic signed [28:0] ang_prod, ang_sum;
    logic signed [16:0] ang_q, ang_max17;
    assign turn      = (r_alpha > PI_9_Q12) || (r_alpha < -PI_9_Q12);
    assign max_ang16 = {1'b0, r_max_ang};
    assign lin_sum   = mul_p[35:0] + 36'd128;
    assign lin_q     = lin_sum[35:8];
    assign ang_mag   = mul_p[26:0];
    assign ang_prod  = r_alpha[15] ? -signed'({2'b0, ang_mag}) : signed'({2'b0, ang_mag});
    assign ang_sum   = ang_prod + 29'sd2048;
    assign ang_q     = ang_sum[28:12];
    assign ang_max17 = signed'({2'b0, r_max_ang});

    // multiplier requests
    always_comb begin
        mul_req.start = 1'b0;
        mul_req.len   = '0;
        mul_a         = '0;
        mul_b         = '0;
        unique case (r_state)
            S_CORD: begin
                // load the x that the last iteration produces
                mul_req.start = (r_i == LAST_IT);
                mul_req.len   = MLW'(MBW);
                mul_a         = CORDIC_K_Q30;
                mul_b         = x_nx[XW-1] ? '0 : MBW'(unsigned'(x_nx));
            end
            S_EVAL: begin
                mul_req.start = !(r_r < RW'(r_arrive)) && !turn;
                mul_req.len   = MLW'(RW);
                mul_a         = MAW'(r_gain_lin);
                mul_b         = MBW'(r_r);
            end
            S_LIN: begin
                mul_req.start = mul_done;
                mul_req.len   = MLW'(11);
                mul_a         = MAW'(r_gain_ang);
                mul_b         = r_alpha[15] ? MBW'(unsigned'(-r_alpha)) :
                                              MBW'(unsigned'(r_alpha));
            end
            default: ;
        endcase
    end

    gtg_sermul #(
        .A_W (MAW),
        .B_W (MBW),
        .P_W (MPW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_prod  (mul_p),
        .o_done  (mul_done)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_xfer) n_state = (i_mode == MODE_STEP) ? S_PRE : S_DONE;
            S_PRE:  n_state = S_CORD;
            S_CORD: if (r_i == LAST_IT) n_state = S_MAG;
            S_MAG:  if (mul_done) n_state = S_EVAL;
            S_EVAL: n_state = mul_req.start ? S_LIN : S_DONE;
            S_LIN:  if (mul_done) n_state = S_ANG;
            S_ANG:  if (mul_done) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_th <= i_pose_heading;
                r_dx <= DW'(r_org_x) + DW'(r_goal_x) - DW'(signed'(i_pose_x));
                r_dy <= DW'(r_org_y) + DW'(r_goal_y) - DW'(signed'(i_pose_y));
                r_cv <= (i_mode != MODE_START);
                r_stat <= (i_mode == MODE_START) ? STAT_INIT : STAT_TERM;
                r_lin <= '0;
                r_ang <= '0;
            end
            S_PRE: begin
                r_i <= '0;
                if (x0 < 0) begin
                    if (y0 >= 0) begin
                        r_x <= y0;  r_y <= -x0; r_z <= HALF_PI_Q30;
                    end else begin
                        r_x <= -y0; r_y <= x0;  r_z <= -HALF_PI_Q30;
                    end
                end else begin
                    r_x <= x0; r_y <= y0; r_z <= '0;
                end
            end
            S_CORD: begin
                r_i <= r_i + 1'b1;
                if (!r_y[XW-1]) begin
                    r_x <= r_x + ys; r_y <= r_y - xs; r_z <= r_z + atan_z;
                end else begin
                    r_x <= r_x - ys; r_y <= r_y + xs; r_z <= r_z - atan_z;
                end
            end
            S_MAG: begin
                if (mul_done) begin
                    r_r     <= mag_sum[60:42];
                    r_alpha <= alpha_w[15:0];
                end
            end
            S_EVAL: begin
                if (r_r < RW'(r_arrive)) begin
                    r_stat <= STAT_DONE;
                    r_cv   <= 1'b0;
                end else begin
                    r_stat <= STAT_RUN;
                    r_cv   <= 1'b1;
                    if (turn) r_ang <= (r_alpha > 0) ? max_ang16 : -max_ang16;
                end
            end
            S_LIN: begin
                if (mul_done)
                    r_lin <= (lin_q > 28'(r_max_lin)) ? {1'b0, r_max_lin} : lin_q[15:0];
            end
            S_ANG: begin
                if (mul_done) begin
                    priority if (ang_q > ang_max17)  r_ang <= max_ang16;
                    else if (ang_q < -ang_max17)     r_ang <= -max_ang16;
                    else                             r_ang <= ang_q[15:0];
                end
            end
            default: ;
        endcase
    end

    // output register: load when done and free, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_ostat <= r_stat;
            r_ocv   <= r_cv;
            r_olin  <= r_lin;
            r_oang  <= r_ang;
        end
    end

    assign o_valid            = r_ovalid;
    assign o_status           = r_ostat;
    assign o_command_valid    = r_ocv;
    assign o_linear_velocity  = r_olin;
    assign o_angular_velocity = r_oang;

    // no command means zero velocities
    a_zero_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_command_valid |-> o_linear_velocity == '0 && o_angular_velocity == '0)
        else $error("velocities set without a command");

    // command flag follows status
    a_cv_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_command_valid == (o_status == STAT_RUN || o_status == STAT_TERM)))
        else $error("command_valid disagrees with status");

    // forward velocity never negative
    a_lin_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_linear_velocity[15])
        else $error("negative linear velocity");

    // finished result waits while output is held
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && r_ovalid && i_stall |=> r_state == S_DONE)
        else $error("result lost under stall");

endmodule
`default_nettype wire

// ===== dv/go_to_goal_velocity_controller_test.sv =====
// Testbench for the go-to-goal velocity controller: directed and random poses, scoreboard check.
`default_nettype none
module go_to_goal_velocity_controller_test;
    import gtg_pkg::*;

    localparam int STEPS = CORDIC_STEPS_DEF;
    localparam logic [1:0] MODE_STOP = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic        cmd;
        logic [15:0] lin;
        logic [15:0] ang;
    } t_cmd;

    int errors = 0;

    // report one mismatch and count it
    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    endtask

    // controller predictor and expected command store
    class velocity_board;
        longint gx, gy, rel, arrive, kl, ka, vmax, wmax, ox, oy;
        t_cmd pending[$];

        function void clear();
            gx = 0; gy = 0; rel = 0; arrive = 26;
            kl = 4096; ka = 4096; vmax = 4096; wmax = 4096; ox = 0; oy = 0;
        endfunction

        function void write_reg(logic [CFG_IW-1:0] idx, logic [15:0] d);
            case (idx)
                CFG_GOAL_X:   gx = longint'($signed(d));
                CFG_GOAL_Y:   gy = longint'($signed(d));
                CFG_RELATIVE: rel = d[0];
                CFG_ARRIVE:   arrive = d[14:0];
                CFG_GAIN_LIN: kl = d;
                CFG_GAIN_ANG: ka = d;
                CFG_MAX_LIN:  vmax = d[14:0];
                CFG_MAX_ANG:  wmax = d[14:0];
                default: ;
            endcase
        endfunction

        // note an accepted pose and predict its command
        function void note_pose(logic [1:0] mode, logic [15:0] px_b, logic [15:0] py_b,
                                logic [14:0] th_b);
            longint px, py, th, dx, dy, x, y, z, t, xs, ys, r, brg, alpha, lin, ang;
            t_cmd c;
            px = longint'($signed(px_b)); py = longint'($signed(py_b));
            th = longint'($signed(th_b));
            c = '0; lin = 0; ang = 0;
            if (mode == MODE_START) begin
                ox = rel ? px : 0;
                oy = rel ? py : 0;
                c.status = STAT_INIT;
            end else if (mode == MODE_STEP) begin
                dx = ox + gx - px; dy = oy + gy - py;
                x = dx * 4096; y = dy * 4096; z = 0;
                if (x < 0) begin
                    if (y >= 0) begin
                        t = x; x = y; y = -t; z = HALF_PI_Q30;
                    end else begin
                        t = x; x = -y; y = t; z = -HALF_PI_Q30;
                    end
                end
                for (int i = 0; i < STEPS; i++) begin
                    xs = x >>> i; ys = y >>> i;
                    if (y >= 0) begin
                        x = x + ys; y = y - xs; z += longint'(atan_q30(i));
                    end else begin
                        x = x - ys; y = y + xs; z -= longint'(atan_q30(i));
                    end
                end
                if (x < 0) x = 0;
                r = (((x * longint'(CORDIC_K_Q30)) >>> 30) + 2048) >>> 12;
                brg = (dx == 0 && dy == 0) ? 0 : (z + 131072) >>> 18;
                if (r < arrive) begin
                    c.status = STAT_DONE;
                end else begin
                    c.status = STAT_RUN; c.cmd = 1;
                    alpha = brg - th;
                    while (alpha > 12868) alpha -= 25736;
                    while (alpha < -12868) alpha += 25736;
                    if (alpha > 1430 || alpha < -1430) begin
                        ang = alpha > 0 ? wmax : -wmax;
                    end else begin
                        lin = (kl * r + 128) >>> 8;
                        if (lin > vmax) lin = vmax;
                        ang = (ka * alpha + 2048) >>> 12;
                        if (ang > wmax) ang = wmax;
                        if (ang < -wmax) ang = -wmax;
                    end
                end
            end else begin
                c.status = STAT_TERM; c.cmd = 1;
            end
            c.lin = lin[15:0]; c.ang = ang[15:0];
            pending.push_back(c);
        endfunction

        // compare a delivered command with the oldest prediction
        task check_cmd(t_cmd got);
            t_cmd w;
            if (pending.size() == 0) begin
                report("unexpected result", got.status, -1);
                return;
            end
            w = pending.pop_front();
            if (got.status != w.status) report("status", got.status, w.status);
            if (got.cmd != w.cmd) report("command_valid", got.cmd, w.cmd);
            if (got.lin != w.lin)
                report("linear", $signed(got.lin), $signed(w.lin));
            if (got.ang != w.ang)
                report("angular", $signed(got.ang), $signed(w.ang));
        endtask
    endclass

    logic clk = 0, rst_n = 0;
    logic in_valid = 0, out_stall = 0, stall_to_dut, out_valid;
    logic [1:0] mode = '0;
    logic [15:0] pose_x = '0, pose_y = '0;
    logic [14:0] heading = '0;
    logic [1:0] status;
    logic cmd_valid;
    logic [15:0] lin_vel, ang_vel;
    logic cfg_we = 0;
    logic [CFG_IW-1:0] cfg_idx = '0;
    logic [15:0] cfg_data = '0;
    int send_idle = 0, recv_idle = 0;
    velocity_board board = new();

    always #1 clk = ~clk;

    go_to_goal_velocity_controller u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(stall_to_dut),
        .i_mode(mode), .i_pose_x(pose_x), .i_pose_y(pose_y), .i_pose_heading(heading),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_status(status), .o_command_valid(cmd_valid),
        .o_linear_velocity(lin_vel), .o_angular_velocity(ang_vel),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    // check results and toggle the receiver stall
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            board.check_cmd('{status, cmd_valid, lin_vel, ang_vel});
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    // hand one pose to the block, holding it until the transfer
    task automatic send_pose(input logic [1:0] m, input logic [15:0] px,
                             input logic [15:0] py, input logic [14:0] th);
        while ($urandom_range(99) < send_idle) @(posedge clk);
        in_valid <= 1; mode <= m; pose_x <= px; pose_y <= py; heading <= th;
        @(posedge clk);
        while (stall_to_dut) @(posedge clk);
        board.note_pose(m, px, py, th);
        in_valid <= 0;
        @(posedge clk);
    endtask

    // drain outstanding commands, then let the block settle
    task automatic drain();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [15:0] d);
        cfg_we <= 1; cfg_idx <= idx; cfg_data <= d;
        @(posedge clk);
        board.write_reg(idx, d);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    // heading mostly in range, sometimes any value
    function automatic logic [14:0] rand_heading();
        if ($urandom_range(9) == 0) return 15'($urandom);
        return 15'($signed($urandom_range(25736)) - 12868);
    endfunction

    // random setting of all registers, goal and arrival radius biased to useful values
    task automatic random_setup();
        write_reg(CFG_GOAL_X, 16'($urandom_range(1) ? $urandom : $urandom_range(4000) - 2000));
        write_reg(CFG_GOAL_Y, 16'($urandom_range(1) ? $urandom : $urandom_range(4000) - 2000));
        write_reg(CFG_RELATIVE, 16'($urandom));
        write_reg(CFG_ARRIVE, 16'($urandom_range(3) == 0 ? $urandom : $urandom_range(600)));
        write_reg(CFG_GAIN_LIN, 16'($urandom));
        write_reg(CFG_GAIN_ANG, 16'($urandom));
        write_reg(CFG_MAX_LIN, 16'($urandom));
        write_reg(CFG_MAX_ANG, 16'($urandom));
    endtask

    // a start, then a run of steps near the start pose with some far poses and stops
    task automatic random_run(input int n);
        logic [15:0] bx, by;
        bx = 16'($urandom); by = 16'($urandom);
        send_pose(MODE_START, bx, by, rand_heading());
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0)
                send_pose(MODE_STOP | 2'($urandom_range(1)), 16'($urandom), 16'($urandom),
                          15'($urandom));
            else if ($urandom_range(3) == 0)
                send_pose(MODE_STEP, 16'($urandom), 16'($urandom), rand_heading());
            else
                send_pose(MODE_STEP, bx + 16'($urandom_range(800)) - 16'd400,
                          by + 16'($urandom_range(800)) - 16'd400, rand_heading());
        end
    endtask

    initial begin
        board.clear();
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, every mode, goal on the pose, odd headings
        send_pose(MODE_STEP, 16'd0, 16'd0, 15'd0);
        send_pose(MODE_STEP, 16'h8000, 16'h7fff, 15'h7fff);
        send_pose(MODE_STEP, 16'h7fff, 16'h8000, 15'h4000);
        send_pose(MODE_STEP, 16'hffff, 16'h8000, 15'd12868);
        send_pose(MODE_STOP, 16'hffff, 16'hffff, 15'h7fff);
        send_pose(MODE_SPARE, 16'h0, 16'h0, 15'h0);
        drain();
        write_reg(CFG_GOAL_X, 16'h7fff); write_reg(CFG_GOAL_Y, 16'h8000);
        write_reg(CFG_RELATIVE, 16'd1); write_reg(CFG_ARRIVE, 16'h7fff);
        write_reg(CFG_GAIN_LIN, 16'hffff); write_reg(CFG_GAIN_ANG, 16'hffff);
        write_reg(CFG_MAX_LIN, 16'h7fff); write_reg(CFG_MAX_ANG, 16'h7fff);
        write_reg(4'd9, 16'h1234);
        send_pose(MODE_START, 16'h8000, 16'h7fff, 15'h0);
        send_pose(MODE_STEP, 16'h8000, 16'h7fff, 15'h0);
        send_pose(MODE_STEP, 16'h7fff, 16'h8000, 15'h3000);
        drain();
        write_reg(CFG_ARRIVE, 16'd0); write_reg(CFG_MAX_LIN, 16'd0);
        write_reg(CFG_MAX_ANG, 16'd0); write_reg(CFG_GAIN_LIN, 16'd0);
        send_pose(MODE_STEP, 16'd0, 16'd0, -15'sd12868);
        send_pose(MODE_STEP, 16'h1234, 16'h0fed, 15'd100);
        send_pose(MODE_START, 16'd50, 16'd60, 15'd0);
        send_pose(MODE_STEP, 16'd50, 16'd60, 15'd1430);
        drain();
        write_reg(CFG_RELATIVE, 16'd0); write_reg(CFG_GOAL_X, 16'd256);
        write_reg(CFG_GOAL_Y, 16'd0); write_reg(CFG_MAX_LIN, 16'd8192);
        write_reg(CFG_MAX_ANG, 16'd8192); write_reg(CFG_GAIN_LIN, 16'd4096);
        write_reg(CFG_GAIN_ANG, 16'd8192);
        send_pose(MODE_START, 16'd9, 16'd9, 15'd0);
        send_pose(MODE_STEP, 16'd0, 16'd0, 15'd1430);
        send_pose(MODE_STEP, 16'd0, 16'd0, -15'sd1431);
        send_pose(MODE_STEP, 16'd0, 16'd10, 15'd200);
        drain();

        // random phases over three idling patterns
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 23 : (ph == 1) ? 57 : 0;
            recv_idle = (ph == 0) ? 57 : (ph == 1) ? 23 : 0;
            for (int k = 0; k < 8; k++) begin
                random_setup();
                random_run(40);
                drain();
            end
        end

        drain();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
